>>> hdl/tneb_pkg.sv
// Shared types, sizes and codes for the trigger number event builder.
// No dependencies.
package tneb_pkg;
  localparam int NUM_SOURCES = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int SRC_W       = 3;
  localparam int QUEUE_W     = 4;
  localparam int WORD_W      = 32;

  localparam logic [1:0] CMD_RECEIVE    = 2'd0;
  localparam logic [1:0] CMD_CONNECT    = 2'd1;
  localparam logic [1:0] CMD_DISCONNECT = 2'd2;
  localparam logic [1:0] CMD_CLEAR      = 2'd3;

  localparam logic [1:0] ST_EMIT     = 2'd0;
  localparam logic [1:0] ST_NOT_TRIG = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] trig;
    logic [SRC_W-1:0]  src;
    logic [WORD_W-1:0] tag;
    logic              last;
  } result_t;
endpackage

>>> hdl/tneb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tneb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/trigger_number_event_builder_core.sv
// Top level of the trigger number event builder: sequencer, per-source queue pointers and
// one shared queue RAM (tneb_ram); sizes and codes come from tneb_pkg.
// One input transaction is handled at a time and in_tready is low meanwhile. Connect,
// disconnect and clear pass through S_CMD only; a rejected receive then waits in S_WAIT
// until its result is taken by out_tready. A stored receive scans the source fronts through
// the single RAM read port and one 32-bit comparator, in S_RD and S_CMP for a known source
// and in S_RD only for an unknown one, stopping early at a known empty queue. A build then
// walks the sources in S_SEL up to the last match, emits each result in S_EMIT and drains
// in S_WAIT, held by out_tready stalls. No clearing pass; queue counters reset at once.
module trigger_number_event_builder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // source[2:0], trigger_number[34:3], event_tag[66:35],
                                 // zero fill
  input  logic [2:0]  in_tuser,  // command[1:0], is_trigger[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata, // out_trigger[31:0], out_source[34:32], out_tag[66:35],
                                 // zero fill
  output logic [1:0]  out_tuser, // status[1:0]
  output logic        out_tlast
);
  localparam int NS = tneb_pkg::NUM_SOURCES;
  localparam int NW = tneb_pkg::SRC_W;
  localparam int QW = tneb_pkg::QUEUE_W;
  localparam int CW = QW + 1;
  localparam int AW = NW + QW;
  localparam int SW = NW + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_CMD  = 7'b0000010, S_RD   = 7'b0000100,
    S_CMP  = 7'b0001000, S_SEL  = 7'b0010000, S_EMIT = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]    cmd_r;
  logic [NW-1:0] src_r;
  logic [31:0]   trig_r, tag_r;
  logic          istrig_r;
  logic [QW-1:0] head_r [NS];
  logic [CW-1:0] cnt_r  [NS];
  logic [NS-1:0] known_r, inact_r, hit_r;
  logic [NW-1:0] scan_r;
  logic [31:0]   min_r;
  tneb_pkg::result_t res_r;
  logic          ovalid_r;

  logic [63:0]   rdata;
  logic          we;
  logic          full, store, last_idx, front_empty, more_hits, out_free;
  logic          load_rej, load_emit;
  logic [AW-1:0] waddr, raddr;
  logic [QW-1:0] wpos;
  logic [SW-1:0] n_in, n_kn;
  logic [NS-1:0] rem_hit, forget;

  assign full        = (cnt_r[src_r] >= CW'(tneb_pkg::QUEUE_DEPTH));
  assign store       = (cmd_r == tneb_pkg::CMD_RECEIVE) && istrig_r && !full;
  assign wpos        = head_r[src_r] + cnt_r[src_r][QW-1:0];
  assign waddr       = {src_r, wpos};
  assign raddr       = {scan_r, head_r[scan_r]};
  assign we          = (state_r == S_CMD) && store;
  assign last_idx    = (scan_r == NW'(NS - 1));
  assign front_empty = known_r[scan_r] && (cnt_r[scan_r] == '0);
  assign more_hits   = (rem_hit != '0);
  assign out_free    = !ovalid_r || out_tready;
  assign load_rej    = (state_r == S_CMD) && (cmd_r == tneb_pkg::CMD_RECEIVE) && !store;
  assign load_emit   = (state_r == S_EMIT) && out_free;

  tneb_ram #(.WIDTH(64), .DEPTH(NS * tneb_pkg::QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata({trig_r, tag_r}),
    .raddr(raddr), .rdata(rdata));

  always_comb begin
    n_in    = '0;
    n_kn    = '0;
    rem_hit = '0;
    forget  = '0;
    for (int i = 0; i < NS; i++) begin
      n_in = n_in + SW'(inact_r[i] | (src_r == NW'(i)));
      n_kn = n_kn + SW'(known_r[i]);
      if (NW'(i) > scan_r) rem_hit[i] = hit_r[i];
      // count after the pop of the current source
      forget[i] = inact_r[i] && known_r[i] && (cnt_r[i] == CW'(scan_r == NW'(i)));
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tlast  = res_r.last;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {5'd0, res_r.tag, res_r.src, res_r.trig};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_CMD;
      S_CMD: begin
        if (store) state_nxt = S_RD;
        else if (cmd_r == tneb_pkg::CMD_RECEIVE) state_nxt = S_WAIT;
        else state_nxt = S_IDLE;
      end
      S_RD: begin
        if (front_empty) state_nxt = S_IDLE;
        else if (known_r[scan_r]) state_nxt = S_CMP;
        else if (last_idx) state_nxt = S_SEL;
      end
      S_CMP:  state_nxt = last_idx ? S_SEL : S_RD;
      S_SEL:  if (hit_r[scan_r]) state_nxt = S_EMIT;
      S_EMIT: if (out_free) state_nxt = more_hits ? S_SEL : S_WAIT;
      S_WAIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      known_r  <= '0;
      inact_r  <= '0;
      hit_r    <= '0;
      scan_r   <= '0;
      min_r    <= '1;
      ovalid_r <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= load_rej || load_emit || (ovalid_r && !out_tready);
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          cmd_r    <= in_tuser[1:0];
          istrig_r <= in_tuser[2];
          src_r    <= in_tdata[2:0];
          trig_r   <= in_tdata[34:3];
          tag_r    <= in_tdata[66:35];
        end
        S_CMD: begin
          scan_r <= '0;
          min_r  <= '1;
          hit_r  <= '0;
          unique case (cmd_r)
            tneb_pkg::CMD_CLEAR: begin
              known_r <= '0;
              inact_r <= '0;
              for (int i = 0; i < NS; i++) begin
                head_r[i] <= '0;
                cnt_r[i]  <= '0;
              end
            end
            tneb_pkg::CMD_CONNECT: begin
              head_r[src_r]  <= '0;
              cnt_r[src_r]   <= '0;
              known_r[src_r] <= 1'b1;
              inact_r[src_r] <= 1'b0;
            end
            tneb_pkg::CMD_DISCONNECT: begin
              if (n_in == n_kn) begin
                known_r <= '0;
                inact_r <= '0;
                for (int i = 0; i < NS; i++) begin
                  head_r[i] <= '0;
                  cnt_r[i]  <= '0;
                end
              end else begin
                inact_r[src_r] <= 1'b1;
              end
            end
            tneb_pkg::CMD_RECEIVE: begin
              if (store) begin
                cnt_r[src_r]   <= cnt_r[src_r] + CW'(1);
                known_r[src_r] <= 1'b1;
              end else begin
                res_r <= '{istrig_r ? tneb_pkg::ST_FULL : tneb_pkg::ST_NOT_TRIG,
                           trig_r, src_r, tag_r, 1'b1};
              end
            end
          endcase
        end
        S_RD: if (!front_empty && !known_r[scan_r]) begin
          scan_r <= last_idx ? '0 : scan_r + NW'(1);
        end
        S_CMP: begin
          // rdata holds the front of source scan_r
          if (rdata[63:32] < min_r) begin
            min_r <= rdata[63:32];
            hit_r <= NS'(1) << scan_r;
          end else if (rdata[63:32] == min_r) begin
            hit_r[scan_r] <= 1'b1;
          end
          scan_r <= last_idx ? '0 : scan_r + NW'(1);
        end
        S_SEL: if (!hit_r[scan_r]) scan_r <= scan_r + NW'(1);
        S_EMIT: if (out_free) begin
          res_r <= '{tneb_pkg::ST_EMIT, min_r, scan_r, rdata[31:0], !more_hits};
          head_r[scan_r] <= head_r[scan_r] + QW'(1);
          cnt_r[scan_r]  <= cnt_r[scan_r] - CW'(1);
          hit_r[scan_r]  <= 1'b0;
          if (more_hits) begin
            scan_r <= scan_r + NW'(1);
          end else begin
            known_r <= known_r & ~forget;
            inact_r <= inact_r & ~forget;
          end
        end
        S_WAIT: ;
        default: ;
      endcase
    end
  end

  property p_busy_not_ready;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_tready;
  endproperty
  assert property (p_busy_not_ready) else $error("ready while busy");

  property p_emit_has_hit;
    @(posedge clk) disable iff (!rst_n) (state_r == S_EMIT) |-> hit_r[scan_r];
  endproperty
  assert property (p_emit_has_hit) else $error("emit without matching front");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata)
                                      && $stable(out_tuser) && $stable(out_tlast);
  endproperty
  assert property (p_out_hold) else $error("result changed while stalled");
endmodule

>>> verif/trigger_number_event_builder_core_test.sv
// Self-checking testbench for trigger_number_event_builder_core.
// Depends on tneb_pkg and the core RTL; drives random and directed stream traffic
// and compares every result transaction against a built-in behavioral predictor.
`timescale 1ns / 100ps

module trigger_number_event_builder_core_test;
  localparam int NSRC    = tneb_pkg::NUM_SOURCES;
  localparam int DEPTH   = tneb_pkg::QUEUE_DEPTH;
  localparam int LIMIT   = 100000;
  localparam int PEND_MAX = 1024;
  localparam int RES_MAX  = 4096;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  src;
    logic [31:0] trig;
    logic        is_trig;
    logic [31:0] tag;
  } item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  trigger_number_event_builder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  item_t             pending_items [PEND_MAX];
  int                pend_wr = 0;
  int                pend_rd = 0;
  tneb_pkg::result_t built_results [RES_MAX];
  int                res_wr = 0;
  int                res_rd = 0;
  item_t             drv_item;

  logic [63:0]     fifo_mem [NSRC][DEPTH];
  int              fifo_head [NSRC];
  int              fifo_count [NSRC];
  logic [NSRC-1:0] known_srcs;
  logic [NSRC-1:0] idle_srcs;

  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int received = 0;
  int emitted = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 61;

  function automatic void add_item(item_t it);
    pending_items[pend_wr] = it;
    pend_wr++;
  endfunction

  function automatic void wipe_builder();
    for (int s = 0; s < NSRC; s++) begin
      fifo_head[s] = 0;
      fifo_count[s] = 0;
    end
    known_srcs = '0;
    idle_srcs = '0;
  endfunction

  function automatic void add_result(logic [1:0] st, logic [31:0] trig, logic [2:0] src,
                                     logic [31:0] tag, logic lst);
    tneb_pkg::result_t r;
    r.status = st;
    r.trig = trig;
    r.src = src;
    r.tag = tag;
    r.last = lst;
    built_results[res_wr] = r;
    res_wr++;
  endfunction

  function automatic void build_event(item_t it);
    logic [31:0] minv;
    int          first_idx;
    int          n;
    int          pos;
    logic [63:0] e;
    if (it.cmd == tneb_pkg::CMD_CLEAR) begin
      wipe_builder();
      return;
    end
    if (it.cmd == tneb_pkg::CMD_CONNECT) begin
      fifo_head[it.src] = 0;
      fifo_count[it.src] = 0;
      known_srcs[it.src] = 1'b1;
      idle_srcs[it.src] = 1'b0;
      return;
    end
    if (it.cmd == tneb_pkg::CMD_DISCONNECT) begin
      idle_srcs[it.src] = 1'b1;
      if ($countones(idle_srcs) == $countones(known_srcs)) wipe_builder();
      return;
    end
    if (!it.is_trig) begin
      add_result(tneb_pkg::ST_NOT_TRIG, it.trig, it.src, it.tag, 1'b1);
      return;
    end
    if (fifo_count[it.src] >= DEPTH) begin
      add_result(tneb_pkg::ST_FULL, it.trig, it.src, it.tag, 1'b1);
      return;
    end
    pos = (fifo_head[it.src] + fifo_count[it.src]) % DEPTH;
    fifo_mem[it.src][pos] = {it.trig, it.tag};
    fifo_count[it.src]++;
    known_srcs[it.src] = 1'b1;
    minv = '1;
    for (int s = 0; s < NSRC; s++) begin
      if (known_srcs[s]) begin
        if (fifo_count[s] == 0) return;
        e = fifo_mem[s][fifo_head[s]];
        if (e[63:32] < minv) minv = e[63:32];
      end
    end
    first_idx = res_wr;
    n = 0;
    for (int s = 0; s < NSRC; s++) begin
      if (known_srcs[s]) begin
        e = fifo_mem[s][fifo_head[s]];
        if (e[63:32] == minv) begin
          add_result(tneb_pkg::ST_EMIT, minv, s[2:0], e[31:0], 1'b0);
          n++;
          fifo_head[s] = (fifo_head[s] + 1) % DEPTH;
          fifo_count[s]--;
        end
      end
    end
    if (n > 0) built_results[first_idx + n - 1].last = 1'b1;
    for (int s = 0; s < NSRC; s++) begin
      if (idle_srcs[s] && known_srcs[s] && fifo_count[s] == 0) begin
        known_srcs[s] = 1'b0;
        idle_srcs[s] = 1'b0;
      end
    end
  endfunction

  function automatic item_t make_item(logic [1:0] cmd, logic [2:0] src, logic [31:0] trig,
                                      logic is_trig, logic [31:0] tag);
    item_t it;
    it.cmd = cmd;
    it.src = src;
    it.trig = trig;
    it.is_trig = is_trig;
    it.tag = tag;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        build_event(drv_item);
        sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pend_rd < pend_wr && $urandom_range(99) >= send_idle_pct) begin
          drv_item  <= pending_items[pend_rd];
          in_tdata  <= {5'd0, pending_items[pend_rd].tag, pending_items[pend_rd].trig,
                        pending_items[pend_rd].src};
          in_tuser  <= {pending_items[pend_rd].is_trig, pending_items[pend_rd].cmd};
          in_tvalid <= 1'b1;
          pend_rd++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tneb_pkg::result_t got;
    tneb_pkg::result_t want;
    cycles++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.trig = out_tdata[31:0];
        got.src = out_tdata[34:32];
        got.tag = out_tdata[66:35];
        got.last = out_tlast;
        received++;
        if (res_rd == res_wr) begin
          $error("result transaction with nothing expected: %h", out_tdata);
          errors++;
        end else begin
          want = built_results[res_rd];
          res_rd++;
          if (got.status == tneb_pkg::ST_EMIT) emitted++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); errors++;
          end
          if (got.trig !== want.trig) begin
            $error("out_trigger: expected %h, got %h", want.trig, got.trig); errors++;
          end
          if (got.src !== want.src) begin
            $error("out_source: expected %0d, got %0d", want.src, got.src); errors++;
          end
          if (got.tag !== want.tag) begin
            $error("out_tag: expected %h, got %h", want.tag, got.tag); errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pend_rd < pend_wr || in_tvalid || res_rd < res_wr)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  // burst: connect sources, feed nondecreasing triggers with gaps, disconnect some
  task automatic queue_burst();
    logic [7:0]  srcs;
    logic [31:0] base;
    int          nevt;
    srcs = 8'($urandom_range(255, 1));
    base = $urandom();
    nevt = $urandom_range(2, 5);
    for (int s = 0; s < NSRC; s++)
      if (srcs[s])
        add_item(make_item(tneb_pkg::CMD_CONNECT, 3'(s), $urandom(), 1'b0, $urandom()));
    for (int k = 0; k < nevt; k++)
      for (int s = 0; s < NSRC; s++)
        if (srcs[s] && $urandom_range(9) > 1)
          add_item(make_item(tneb_pkg::CMD_RECEIVE, 3'(s), base + k + $urandom_range(1),
                             $urandom_range(9) != 0, $urandom()));
    if ($urandom_range(3) == 0)
      add_item(make_item(2'($urandom_range(3)), 3'($urandom()), $urandom(),
                         1'($urandom_range(1)), $urandom()));
    for (int s = 0; s < NSRC; s++)
      if (srcs[s] && $urandom_range(3) != 0)
        add_item(make_item(tneb_pkg::CMD_DISCONNECT, 3'(s), $urandom(), 1'b0, $urandom()));
  endtask

  initial begin
    int phase_start;
    wipe_builder();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, non-trigger, full queue, lone-source build,
    // disconnect of unknown source, clear all
    add_item(make_item(tneb_pkg::CMD_RECEIVE, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    add_item(make_item(tneb_pkg::CMD_RECEIVE, 3'd0, 32'h0, 1'b1, 32'h0));
    add_item(make_item(tneb_pkg::CMD_CONNECT, 3'd1, 32'h0, 1'b0, 32'h0));
    add_item(make_item(tneb_pkg::CMD_CONNECT, 3'd7, 32'h0, 1'b0, 32'h0));
    for (int k = 0; k < DEPTH + 1; k++)
      add_item(make_item(tneb_pkg::CMD_RECEIVE, 3'd1, 32'hFFFF_FFF0 + k, 1'b1,
                         32'hA5A5_0000 + k));
    add_item(make_item(tneb_pkg::CMD_RECEIVE, 3'd7, 32'hFFFF_FFF0, 1'b1, 32'h5A5A_5A5A));
    add_item(make_item(tneb_pkg::CMD_DISCONNECT, 3'd4, 32'h0, 1'b0, 32'h0));
    add_item(make_item(tneb_pkg::CMD_DISCONNECT, 3'd1, 32'h0, 1'b0, 32'h0));
    add_item(make_item(tneb_pkg::CMD_CLEAR, 3'd2, 32'h0, 1'b0, 32'h0));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 12 : 0;
      phase_start = pend_wr;
      while (pend_wr - phase_start < 60) queue_burst();
      if (phase == 2) add_item(make_item(tneb_pkg::CMD_CLEAR, 3'd0, 32'h0, 1'b0, 32'h0));
      wait_drained();
    end

    if (res_rd != res_wr) begin
      $error("results: expected %0d more, got none", res_wr - res_rd);
      errors++;
    end
    $display("sent %0d input transactions, checked %0d results (%0d built sub-events)",
             sent, received, emitted);
    $display("covered all commands, rejects, full queues and multi-source builds under stalls");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/tneb_pkg.sv
hdl/tneb_ram.sv
hdl/trigger_number_event_builder_core.sv
verif/trigger_number_event_builder_core_test.sv
